/* src/dqls_pkg.sv */
// Shared types and constants for the double-ended queue with linear search.
package dqls_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CMD_W         = 3;
   localparam int WORD_W        = 32;
   localparam int STATUS_W      = 2;
   localparam int OUT_W         = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_SEARCH     = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE      = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

endpackage

/* src/dqls_store.sv */
// Ring store: one write port, one read port with registered read data.
module dqls_store #(
   parameter int DEPTH = dqls_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic signed [dqls_pkg::WORD_W-1:0]  wr_data,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic signed [dqls_pkg::WORD_W-1:0]  rd_data
);
   import dqls_pkg::*;

   logic signed [WORD_W-1:0] entry_store_ff [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/deque_with_linear_search_unit.sv */
// Top level: bounded deque in a ring store with a front-to-back linear search.
//
//   channel   ports                                      transfer
//   request   start, busy, req_cmd, req_value            start && !busy
//   response  rsp_strobe, rsp_status, rsp_found,         rsp_strobe (one cycle)
//             rsp_position, rsp_fill_count
//
// Push, pop and unused commands leave busy low, so they can issue every
// cycle while no search is scanning, and the response strobes on the next cycle.
// A search on a non-empty queue reads entries from the front, one at a time
// through the store's one read port and its registered read data, until the
// match or the end. busy is high during the scan.
// Synchronous reset empties the queue; the store itself is not cleared.
// The receiver cannot stall: each response is valid for one cycle only.
module deque_with_linear_search_unit #(
   parameter int DEPTH = dqls_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [dqls_pkg::CMD_W-1:0]            req_cmd,
   input  logic signed [dqls_pkg::WORD_W-1:0]    req_value,
   output logic                                  rsp_strobe,
   output logic [dqls_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                  rsp_found,
   output logic [dqls_pkg::OUT_W-1:0]            rsp_position,
   output logic [dqls_pkg::OUT_W-1:0]            rsp_fill_count
);
   import dqls_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [AW-1:0]           front_ff, front_in;
   logic [CW-1:0]           count_ff, count_in;
   logic signed [WORD_W-1:0] key_ff, key_in;
   logic [AW-1:0]           off_ff, off_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic                    strobe_ff, strobe_in;
   status_type              status_ff, status_in;
   logic                    found_ff, found_in;
   logic [OUT_W-1:0]        position_ff, position_in;
   logic [OUT_W-1:0]        fill_ff, fill_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [AW-1:0]           rd_addr;
   logic signed [WORD_W-1:0] rd_data;

   logic [SW-1:0]           back_sum;
   logic [AW-1:0]           back_idx;
   logic [AW-1:0]           front_inc;
   logic [AW-1:0]           front_dec;
   logic [AW-1:0]           addr_inc;
   logic                    full;
   logic                    empty;

   dqls_store #(
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_value),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign back_sum  = SW'(front_ff) + SW'(count_ff);
   assign back_idx  = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign addr_inc  = (addr_ff == LAST_IDX) ? '0 : addr_ff + 1'b1;
   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      key_in      = key_ff;
      off_in      = off_ff;
      addr_in     = addr_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      found_in    = found_ff;
      position_in = position_ff;
      fill_in     = fill_ff;
      wr_en       = 1'b0;
      wr_addr     = back_idx;
      rd_addr     = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               strobe_in   = 1'b1;
               status_in   = STAT_DONE;
               found_in    = 1'b0;
               position_in = '0;
               case (cmd_type'(req_cmd))
                  CMD_PUSH_BACK: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = back_idx;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_PUSH_FRONT: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = front_dec;
                        front_in = front_dec;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        front_in = front_inc;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  CMD_SEARCH: begin
                     if (empty) begin
                        status_in = STAT_NOT_FOUND;
                     end else begin
                        strobe_in = 1'b0;
                        rd_addr   = front_ff;
                        addr_in   = front_inc;
                        off_in    = '0;
                        key_in    = req_value;
                        state_in  = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
               fill_in = OUT_W'(count_in);
            end
         end
         ST_SCAN: begin
            if (rd_data == key_ff) begin
               strobe_in   = 1'b1;
               status_in   = STAT_DONE;
               found_in    = 1'b1;
               position_in = OUT_W'(CW'(off_ff) + CW'(1));
               fill_in     = OUT_W'(count_ff);
               state_in    = ST_IDLE;
            end else if (CW'(off_ff) == count_ff - 1'b1) begin
               strobe_in   = 1'b1;
               status_in   = STAT_NOT_FOUND;
               found_in    = 1'b0;
               position_in = '0;
               fill_in     = OUT_W'(count_ff);
               state_in    = ST_IDLE;
            end else begin
               off_in  = off_ff + 1'b1;
               addr_in = addr_inc;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         front_ff  <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      key_ff      <= key_in;
      off_ff      <= off_in;
      addr_ff     <= addr_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      position_ff <= position_in;
      fill_ff     <= fill_in;
   end

   assign busy           = (state_ff == ST_SCAN);
   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_found      = found_ff;
   assign rsp_position   = position_ff;
   assign rsp_fill_count = fill_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= LAST_IDX)
      else $error("front index outside ring");

   a_no_rsp_in_scan: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("response strobe while scanning");

   a_accept_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted command neither answered nor scanning");

   a_scan_end_rsp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("scan ended without a response");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy |-> (!empty && $stable(count_ff) && $stable(front_ff)))
      else $error("queue changed during scan");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the bounded deque with front-to-back linear search.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dqls_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_C = 3'd7;
   localparam int TAIL_ITEMS = 150;
   localparam int RANDOM_ITEMS = 1000;

   typedef struct packed {
      status_type         status;
      logic               found;
      logic [OUT_W-1:0]   position;
      logic [OUT_W-1:0]   fill_count;
   } reply_type;

   class deque_tracker;
      logic [WORD_W-1:0] entries [DEPTH];
      int                front;
      int                count;
      reply_type         expected_replies [$];
      int                failures;

      function new();
         front = 0;
         count = 0;
         failures = 0;
      endfunction

      function reply_type predict_reply(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word);
         reply_type r;
         int        i;
         r = '{STAT_DONE, 1'b0, '0, '0};
         case (cmd)
            CMD_PUSH_BACK: begin
               if (count >= DEPTH) begin
                  r.status = STAT_FULL;
               end else begin
                  entries[(front + count) % DEPTH] = word;
                  count++;
               end
            end
            CMD_PUSH_FRONT: begin
               if (count >= DEPTH) begin
                  r.status = STAT_FULL;
               end else begin
                  front = (front + DEPTH - 1) % DEPTH;
                  entries[front] = word;
                  count++;
               end
            end
            CMD_POP_FRONT: begin
               if (count == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  front = (front + 1) % DEPTH;
                  count--;
               end
            end
            CMD_POP_BACK: begin
               if (count == 0) r.status = STAT_EMPTY;
               else count--;
            end
            CMD_SEARCH: begin
               r.status = STAT_NOT_FOUND;
               for (i = 0; i < count; i++) begin
                  if (entries[(front + i) % DEPTH] == word) begin
                     r.status = STAT_DONE;
                     r.found = 1'b1;
                     r.position = OUT_W'(i + 1);
                     break;
                  end
               end
            end
            default: ;
         endcase
         r.fill_count = OUT_W'(count);
         return r;
      endfunction

      function void note_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word);
         expected_replies.push_back(predict_reply(cmd, word));
      endfunction

      function void compare_field(string field, int unsigned exp, int unsigned act);
         if (exp != act) begin
            failures++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, exp, act);
         end
      endfunction

      function void check_reply(reply_type act);
         reply_type exp;
         if (expected_replies.size() == 0) begin
            failures++;
            $display("%0t ns: unexpected reply, expected none, actual status %0d fill %0d",
                     $time, act.status, act.fill_count);
            return;
         end
         exp = expected_replies.pop_front();
         compare_field("status", exp.status, act.status);
         compare_field("found", exp.found, act.found);
         compare_field("position", exp.position, act.position);
         compare_field("fill_count", exp.fill_count, act.fill_count);
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      // key taken from a live entry so searches hit at every depth
      function logic [WORD_W-1:0] live_entry();
         if (count == 0) return $urandom;
         return entries[(front + $urandom_range(0, count - 1)) % DEPTH];
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [CMD_W-1:0]         req_cmd;
   logic signed [WORD_W-1:0] req_value;
   logic                     rsp_strobe;
   logic [STATUS_W-1:0]      rsp_status;
   logic                     rsp_found;
   logic [OUT_W-1:0]         rsp_position;
   logic [OUT_W-1:0]         rsp_fill_count;

   deque_tracker tracker;
   logic [WORD_W-1:0] word_pool [8];

   deque_with_linear_search_unit #(.DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_found(rsp_found),
      .rsp_position(rsp_position),
      .rsp_fill_count(rsp_fill_count)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_PUSH_BACK;
      req_value = '0;
      tracker = new();
   end

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         tracker.check_reply('{status_type'(rsp_status), rsp_found, rsp_position,
                               rsp_fill_count});
      end
   end

   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word);
      @(negedge clock);
      start = 1'b1;
      req_cmd = cmd;
      req_value = word;
      do @(posedge clock); while (busy);
      tracker.note_command(cmd, word);
   endtask

   task automatic hold_off(input int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain_replies();
      @(negedge clock);
      start = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      if ($urandom_range(0, 1) == 0) return word_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [CMD_W-1:0] pick_command(int push_share, int pop_share);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return CMD_W'($urandom_range(CMD_UNUSED_A, CMD_UNUSED_C));
      if (roll < 3 + push_share)
         return ($urandom_range(0, 1) == 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      if (roll < 3 + push_share + pop_share)
         return ($urandom_range(0, 1) == 0) ? CMD_POP_FRONT : CMD_POP_BACK;
      return CMD_SEARCH;
   endfunction

   initial begin
      logic [CMD_W-1:0]  cmd;
      logic [WORD_W-1:0] word;
      int                push_share;
      int                pop_share;

      word_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty queue corner cases
      send_command(CMD_POP_FRONT, 32'h0);
      send_command(CMD_POP_BACK, 32'hFFFF_FFFF);
      send_command(CMD_SEARCH, 32'h0);
      // fill to capacity from both ends, then push twice more while full
      send_command(CMD_PUSH_BACK, 32'h8000_0000);
      send_command(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
      send_command(CMD_PUSH_BACK, 32'hFFFF_FFFF);
      send_command(CMD_PUSH_FRONT, 32'h0000_0000);
      for (int i = 0; i < DEPTH - 5; i++)
         send_command((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
      send_command(CMD_PUSH_BACK, 32'h0BAD_CAFE);
      send_command(CMD_PUSH_BACK, 32'h1111_1111);
      send_command(CMD_PUSH_FRONT, 32'h2222_2222);
      // searches: deepest entry, front entry, duplicate-free miss
      send_command(CMD_SEARCH, 32'h0BAD_CAFE);
      send_command(CMD_SEARCH, tracker.entries[tracker.front]);
      send_command(CMD_SEARCH, 32'h3333_3333);
      for (int c = CMD_UNUSED_A; c <= CMD_UNUSED_C; c++)
         send_command(CMD_W'(c), $urandom);

      push_share = 35;
      pop_share = 35;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) begin
            case ($urandom_range(0, 2))
               0: begin push_share = 55; pop_share = 20; end
               1: begin push_share = 20; pop_share = 55; end
               default: begin push_share = 35; pop_share = 35; end
            endcase
         end
         if (n == RANDOM_ITEMS / 2) drain_replies();
         cmd = pick_command(push_share, pop_share);
         if (cmd == CMD_SEARCH && $urandom_range(0, 4) != 0) word = tracker.live_entry();
         else word = pick_word();
         send_command(cmd, word);
         if (n < RANDOM_ITEMS - TAIL_ITEMS && (n / 100) % 3 != 2 && $urandom_range(0, 5) == 0)
            hold_off($urandom_range(1, 17));
      end

      drain_replies();
      repeat (DEPTH + 4) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("deque_with_linear_search_unit regression: pass");
      end else begin
         $display("deque_with_linear_search_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("deque_with_linear_search_unit regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
src/dqls_pkg.sv
src/dqls_store.sv
src/deque_with_linear_search_unit.sv
verif/testbench.sv
